// File: rtl/core/swmm_pkg.sv
// Shared types and constants for the sliding-window minimum/maximum block.
// Used by every other .sv file here; depends on nothing else.
package swmm_pkg;

	localparam int DATA_W  = 32;
	localparam int WSIZE_W = 7;
	localparam int PDATA_W = 32;
	localparam int PADDR_W = 3;

	// Register index on the configuration port (byte address 4 * index).
	localparam logic REG_WINDOW_SIZE = 1'b0;

	// Running extremes that travel down the chain of cells.
	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] lo;
		logic signed [DATA_W-1:0] hi;
	} swmm_tok_t;

endpackage

// File: rtl/core/swmm_cell.sv
// One cell of the sample chain: holds one history sample and folds it into
// the passing min/max word when its position lies inside the window.
// Depends on swmm_pkg.
module swmm_cell import swmm_pkg::*; #(
	parameter int CNT_W = 7,
	parameter int IDX   = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     shift_en,
	input  logic signed [DATA_W-1:0] sample_in,
	output logic signed [DATA_W-1:0] sample_out,
	input  logic                     adv_en,
	input  logic [CNT_W-1:0]         win,
	input  swmm_tok_t                tok_in,
	output swmm_tok_t                tok_out
);

	logic signed [DATA_W-1:0] sample_q;
	logic                     tok_valid_q;
	logic signed [DATA_W-1:0] tok_lo_q;
	logic signed [DATA_W-1:0] tok_hi_q;
	logic                     fold;

	// Cells past the window length pass the word on unchanged.
	assign fold = win > CNT_W'(IDX);

	always_ff @(posedge clk) begin
		if (shift_en) begin
			sample_q <= sample_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else if (adv_en) begin
			tok_valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_en) begin
			if (fold && sample_q < tok_in.lo) begin
				tok_lo_q <= sample_q;
			end else begin
				tok_lo_q <= tok_in.lo;
			end
			if (fold && sample_q > tok_in.hi) begin
				tok_hi_q <= sample_q;
			end else begin
				tok_hi_q <= tok_in.hi;
			end
		end
	end

	assign sample_out    = sample_q;
	assign tok_out.valid = tok_valid_q;
	assign tok_out.lo    = tok_lo_q;
	assign tok_out.hi    = tok_hi_q;

endmodule

// File: rtl/core/sliding_window_min_max.sv
// Sliding-window minimum and maximum over a stream of signed 32-bit samples.
// Input channel: sample with in_valid/in_ready; a word is accepted when both
// are high. Output channel: window_min and window_max with out_valid/out_ready.
// Configuration: APB-style port; window_size (7 bits, reset 1) at address 0.
// Zero is used as 1 and values above MAX_WINDOW as MAX_WINDOW.
// Each accepted sample shifts into a chain of MAX_WINDOW cells. Once at least
// the window length of samples has arrived, a min/max word is sent down the
// chain, one cell per cycle while the output is not stalled, and each cell
// inside the window folds in its sample. The result passes the injection
// register and all MAX_WINDOW cells before it reaches the output register.
// While a word is in the chain in_ready is low, so after a producing sample
// the next one waits until the word leaves the chain. A sample that produces
// no result (window not yet full) lets the next one follow at once.
// A stalled receiver holds the result in the output register; the chain
// stops moving until that word is taken, and the next sample is taken while
// the previous result is still waiting.
// Reset clears the fill count, the in-flight words and the output valid flag;
// history contents are never read before they are written.
module sliding_window_min_max import swmm_pkg::*; #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [PADDR_W-1:0]       paddr,
	input  logic [PDATA_W-1:0]       pwdata,
	output logic [PDATA_W-1:0]       prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DATA_W-1:0] sample,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] window_min,
	output logic signed [DATA_W-1:0] window_max
);

	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int CMP_W = (CNT_W > WSIZE_W) ? CNT_W : WSIZE_W;

	logic [WSIZE_W-1:0]       wsize_q;
	logic [CNT_W-1:0]         fill_q;
	logic [CNT_W-1:0]         fill_nxt;
	logic [CMP_W-1:0]         ws_ext;
	logic [CMP_W-1:0]         eff_cmp;
	logic [CNT_W-1:0]         eff_win;
	logic                     busy_q;
	logic                     in_acc;
	logic                     has_result;
	logic                     adv;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] min_q;
	logic signed [DATA_W-1:0] max_q;
	logic                     inj_valid_q;
	logic signed [DATA_W-1:0] inj_lo_q;
	logic signed [DATA_W-1:0] inj_hi_q;
	swmm_tok_t                tok [MAX_WINDOW+1];
	logic signed [DATA_W-1:0] samp [MAX_WINDOW+1];
	logic [MAX_WINDOW:0]      tok_vld;

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = PDATA_W'(wsize_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsize_q <= WSIZE_W'(1);
		end else if (psel && penable && pwrite && paddr[2] == REG_WINDOW_SIZE) begin
			wsize_q <= pwdata[WSIZE_W-1:0];
		end
	end

	// Effective window length, clamped to 1..MAX_WINDOW.
	assign ws_ext = CMP_W'(wsize_q);
	always_comb begin
		if (ws_ext == '0) begin
			eff_cmp = CMP_W'(1);
		end else if (ws_ext > CMP_W'(MAX_WINDOW)) begin
			eff_cmp = CMP_W'(MAX_WINDOW);
		end else begin
			eff_cmp = ws_ext;
		end
	end
	assign eff_win = eff_cmp[CNT_W-1:0];

	assign in_ready   = !busy_q;
	assign in_acc     = in_valid && in_ready;
	assign fill_nxt   = (fill_q == CNT_W'(MAX_WINDOW)) ? fill_q : fill_q + CNT_W'(1);
	assign has_result = fill_nxt >= eff_win;

	// The chain moves unless the output register holds a word not yet taken.
	assign adv = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (in_acc) begin
			fill_q <= fill_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			inj_valid_q <= 1'b0;
		end else begin
			if (in_acc && has_result) begin
				busy_q <= 1'b1;
			end else if (adv && tok[MAX_WINDOW].valid) begin
				busy_q <= 1'b0;
			end
			if (in_acc) begin
				inj_valid_q <= has_result;
			end else if (adv) begin
				inj_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			inj_lo_q <= sample;
			inj_hi_q <= sample;
		end
	end

	assign tok[0]  = '{valid: inj_valid_q, lo: inj_lo_q, hi: inj_hi_q};
	assign samp[0] = sample;

	for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
		swmm_cell #(
			.CNT_W (CNT_W),
			.IDX   (k)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift_en   (in_acc),
			.sample_in  (samp[k]),
			.sample_out (samp[k+1]),
			.adv_en     (adv),
			.win        (eff_win),
			.tok_in     (tok[k]),
			.tok_out    (tok[k+1])
		);
	end

	for (genvar k = 0; k <= MAX_WINDOW; k++) begin : g_vld
		assign tok_vld[k] = tok[k].valid;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= tok[MAX_WINDOW].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tok[MAX_WINDOW].valid) begin
			min_q <= tok[MAX_WINDOW].lo;
			max_q <= tok[MAX_WINDOW].hi;
		end
	end

	assign out_valid  = out_valid_q;
	assign window_min = min_q;
	assign window_max = max_q;

	// At most one word travels through the chain at a time.
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_vld) <= 1)
		else $error("more than one word in the cell chain");

	// A word in the chain always means the input side is held off.
	a_busy_word: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_vld != '0) |-> busy_q)
		else $error("word in flight while input is open");

	// A delivered result is ordered.
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (min_q <= max_q))
		else $error("window minimum above window maximum");

endmodule

// File: tb/swmm_extremes_check.sv
// Checker for sliding_window_min_max: watches the configuration, sample and result channels,
// keeps its own sample history and window length, and scores every result word.
// Depends on swmm_pkg for the data width, address width and register index.
module swmm_extremes_check import swmm_pkg::*; #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic                     pready,
	input  logic [PADDR_W-1:0]       paddr,
	input  logic [PDATA_W-1:0]       pwdata,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic signed [DATA_W-1:0] sample,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic signed [DATA_W-1:0] window_min,
	input  logic signed [DATA_W-1:0] window_max,
	output int                       mismatches,
	output int                       pending,
	output int                       results_checked
);

	typedef struct packed {
		logic signed [DATA_W-1:0] lo;
		logic signed [DATA_W-1:0] hi;
	} extremes_t;

	logic signed [DATA_W-1:0] history [MAX_WINDOW];
	int unsigned              filled;
	int unsigned              next_slot;
	logic [WSIZE_W-1:0]       window_reg;
	extremes_t                expected_extremes [$];

	// Zero acts as one; anything past the history depth covers the whole history.
	function automatic int unsigned span(input logic [WSIZE_W-1:0] w);
		if (w == 0)
			return 1;
		if (w > MAX_WINDOW)
			return MAX_WINDOW;
		return w;
	endfunction

	task automatic take_sample(input logic signed [DATA_W-1:0] s);
		int unsigned              newest;
		int unsigned              len;
		logic signed [DATA_W-1:0] v;
		logic signed [DATA_W-1:0] lo;
		logic signed [DATA_W-1:0] hi;
		extremes_t                e;
		newest = next_slot;
		history[newest] = s;
		next_slot = (newest + 1) % MAX_WINDOW;
		if (filled < MAX_WINDOW)
			filled++;
		len = span(window_reg);
		if (filled >= len) begin
			lo = s;
			hi = s;
			for (int unsigned i = 1; i < len; i++) begin
				v = history[(newest + MAX_WINDOW - i) % MAX_WINDOW];
				if (v < lo)
					lo = v;
				if (v > hi)
					hi = v;
			end
			e.lo = lo;
			e.hi = hi;
			expected_extremes.push_back(e);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		extremes_t want;
		if (!arst_n) begin
			filled = 0;
			next_slot = 0;
			window_reg = 1;
			expected_extremes.delete();
			mismatches = 0;
			pending = 0;
			results_checked = 0;
		end else begin
			if (psel && penable && pwrite && pready && (paddr >> 2) == REG_WINDOW_SIZE)
				window_reg = pwdata[WSIZE_W-1:0];
			if (in_valid && in_ready)
				take_sample(sample);
			if (out_valid && out_ready) begin
				if (expected_extremes.size() == 0) begin
					$error("result word with no sample behind it: window_min %0d window_max %0d",
						window_min, window_max);
					mismatches++;
				end else begin
					want = expected_extremes.pop_front();
					results_checked++;
					if (window_min !== want.lo) begin
						$error("window_min: expected %0d, got %0d", want.lo, window_min);
						mismatches++;
					end
					if (window_max !== want.hi) begin
						$error("window_max: expected %0d, got %0d", want.hi, window_max);
						mismatches++;
					end
				end
			end
			pending = expected_extremes.size();
		end
	end

endmodule

// File: tb/tb_sliding_window_min_max.sv
// Top of the sliding_window_min_max testbench: clock, reset, configuration writes and
// sample stimulus with random idling on both channels, plus the final verdict.
// Depends on swmm_pkg, the block itself and swmm_extremes_check.
module tb_sliding_window_min_max;
	import swmm_pkg::*;

	localparam int MAX_WINDOW   = 64;
	localparam int N_ITEMS      = 650;
	localparam int LIMIT_CYCLES = 600000;
	// A result walks the whole cell chain, so let that much time pass when quiet.
	localparam int DRAIN_CYCLES = MAX_WINDOW + 8;
	// Register index with nothing behind it; writes there must change nothing.
	localparam int REG_UNMAPPED = 1;
	localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7fff_ffff;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [PADDR_W-1:0]       paddr = '0;
	logic [PDATA_W-1:0]       pwdata = '0;
	logic [PDATA_W-1:0]       prdata;
	logic                     pready;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [DATA_W-1:0] sample = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [DATA_W-1:0] window_min;
	logic signed [DATA_W-1:0] window_max;

	int mismatches;
	int pending;
	int results_checked;
	int sent = 0;
	int settings = 0;
	int cycles = 0;
	int ready_hold = 0;
	bit ready_stalls = 1'b1;
	bit sender_idles = 1'b1;

	always #5 clk = ~clk;

	sliding_window_min_max #(.MAX_WINDOW(MAX_WINDOW)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.window_min(window_min), .window_max(window_max)
	);

	swmm_extremes_check #(.MAX_WINDOW(MAX_WINDOW)) extremes_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.window_min(window_min), .window_max(window_max),
		.mismatches(mismatches), .pending(pending), .results_checked(results_checked)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Mostly no pause, sometimes a short one, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(negedge clk) begin
		if (ready_hold > 0)
			ready_hold--;
		else if (!ready_stalls)
			out_ready <= 1'b1;
		else begin
			out_ready <= ($urandom_range(0, 3) != 0);
			ready_hold = idle_len();
		end
	end

	// Entered and left at a falling edge; valid stays up when words follow back to back.
	task automatic push_sample(input logic signed [DATA_W-1:0] v);
		int gap;
		gap = sender_idles ? idle_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			sample <= $urandom;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= v;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic write_reg(input int index, input logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * index);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
	endtask

	// The stray write goes last so that a decoding slip would clobber the window length.
	task automatic apply_window(input logic [WSIZE_W-1:0] w, input bit noisy, input bit poke);
		logic [PDATA_W-1:0] value;
		value = $urandom;
		value[WSIZE_W-1:0] = w;
		if (!noisy)
			value[PDATA_W-1:WSIZE_W] = '0;
		write_reg(REG_WINDOW_SIZE, value);
		if (poke)
			write_reg(REG_UNMAPPED, $urandom);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic signed [DATA_W-1:0] base;
		logic signed [DATA_W-1:0] v;
		int unsigned              stride;
		int                       shape;
		int                       len;
		logic [WSIZE_W-1:0]       w;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset window of one: each word is its own minimum and maximum.
		push_sample(S_MIN);
		push_sample(S_MAX);
		push_sample(0);
		push_sample(-1);
		settle();
		apply_window(1, 1'b1, 1'b1);
		push_sample(1);
		settle();
		apply_window(0, 1'b0, 1'b0);
		push_sample(32'sh5555_5555);
		settle();
		apply_window(4, 1'b0, 1'b0);
		push_sample(32'shaaaa_aaaa);
		push_sample(S_MAX);
		push_sample(7);
		push_sample(S_MIN);
		push_sample(S_MAX);
		// Oversized windows cover the whole history, which is not full yet.
		settle();
		apply_window(100, 1'b0, 1'b0);
		repeat (5) push_sample($urandom);
		settle();
		apply_window(127, 1'b0, 1'b0);
		push_sample(S_MIN);
		push_sample(S_MAX);
		// Shrinking the window keeps the history, so results resume at once.
		settle();
		apply_window(2, 1'b0, 1'b0);
		push_sample(-5);
		push_sample(S_MIN);
		push_sample(3);

		while (sent < N_ITEMS) begin
			settle();
			case ($urandom_range(0, 9))
				0: w = 0;
				1: w = 1;
				2: w = MAX_WINDOW;
				3: w = $urandom_range(MAX_WINDOW + 1, 127);
				4, 5, 6: w = $urandom_range(2, 8);
				default: w = $urandom_range(2, MAX_WINDOW - 1);
			endcase
			apply_window(w, $urandom_range(0, 2) == 0, $urandom_range(0, 3) == 0);
			sender_idles = ($urandom_range(0, 3) != 0);
			ready_stalls = ($urandom_range(0, 3) != 0);
			shape = $urandom_range(0, 3);
			len = $urandom_range(15, 60);
			base = $urandom;
			stride = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 1000) : $urandom;
			for (int k = 0; k < len; k++) begin
				case (shape)
					1: v = base + k * stride;
					2: v = base - k * stride;
					3: v = ($urandom_range(0, 4) == 0) ? $urandom : base;
					default: begin
						case ($urandom_range(0, 9))
							0, 1, 2, 3, 4: v = $urandom;
							5: v = S_MIN;
							6: v = S_MAX;
							default: v = $urandom_range(0, 40) - 20;
						endcase
					end
				endcase
				push_sample(v);
			end
		end

		settle();
		$display("covered %0d samples, %0d checked result words, %0d window settings from 0 to 127",
			sent, results_checked, settings);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: files.f
rtl/core/swmm_pkg.sv
rtl/core/swmm_cell.sv
rtl/core/sliding_window_min_max.sv
tb/swmm_extremes_check.sv
tb/tb_sliding_window_min_max.sv
